// ===== rtl/core/gfop_pkg.sv =====
// Shared types, constants and the arctangent table for the odometry pose block.
`timescale 1ns / 1ps
package gfop_pkg;

   localparam int AtanEntries = 24;
   localparam logic signed [33:0] CordicGain = 34'sd652032874;

   localparam logic [2:0] CSR_DIST_PER_TICK = 3'd0;
   localparam logic [2:0] CSR_HEAD_PER_MM   = 3'd1;
   localparam logic [2:0] CSR_GYRO_OFFSET   = 3'd2;
   localparam logic [2:0] CSR_GYRO_THRESH   = 3'd3;
   localparam logic [2:0] CSR_GYRO_WEIGHT   = 3'd4;
   localparam logic [2:0] CSR_GYRO_SCALE    = 3'd5;

   typedef struct packed {
      logic load;   // capture an input beat and start the pre-CORDIC chain
      logic step;   // advance the pre-CORDIC chain one stage
      logic rot;    // one CORDIC rotation
      logic init;   // seed the rotator
      logic fin;    // scale travel by cos/sin (multiply stage)
      logic acc;    // add into the pose and show the result
   } cmd_type;

   function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/core/gyro_fused_odometry_pose_top.sv =====
// Top level of the gyro-fused differential-drive pose estimator.
//   channel  | handshake            | payload
//   req      | req_valid/req_stall  | ticks_valid, left_count, right_count, gyro_rate
//   rsp      | rsp_valid/rsp_stall  | pos_x, pos_y, heading
//   csr      | csr_write_enable     | csr_index, csr_data
// One beat is worked on at a time; req_stall holds off the next until it is done.
// The iterative CORDIC rotator does one rotation per cycle.
// Reset is synchronous, clears the pose and last counts and sets the registers to defaults.
// A finished result waits in its output register while the next beat is worked on.
`timescale 1ns / 1ps
module gyro_fused_odometry_pose_top #(
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_ticks_valid,
   input  logic [31:0] req_left_count,
   input  logic [31:0] req_right_count,
   input  logic [15:0] req_gyro_rate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [15:0] rsp_heading,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import gfop_pkg::*;

   cmd_type     cmd;
   logic [15:0] dist_ff, hpm_ff, off_ff;
   logic [14:0] thr_ff;
   logic [8:0]  wgt_ff;
   logic [23:0] scl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff <= 16'd125;
         hpm_ff  <= 16'd22250;
         off_ff  <= 16'd0;
         thr_ff  <= 15'd1280;
         wgt_ff  <= 9'd192;
         scl_ff  <= 24'd1192956;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_DIST_PER_TICK: dist_ff <= csr_data[15:0];
            CSR_HEAD_PER_MM:   hpm_ff  <= csr_data[15:0];
            CSR_GYRO_OFFSET:   off_ff  <= csr_data[15:0];
            CSR_GYRO_THRESH:   thr_ff  <= csr_data[14:0];
            CSR_GYRO_WEIGHT:   wgt_ff  <= csr_data[8:0];
            CSR_GYRO_SCALE:    scl_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   gfop_ctrl #(.ANGLE_BITS(ANGLE_BITS)) u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd)
   );

   gfop_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_ticks_valid(req_ticks_valid), .req_left_count(req_left_count),
      .req_right_count(req_right_count), .req_gyro_rate(req_gyro_rate),
      .dist_per_tick(dist_ff), .head_per_mm(hpm_ff), .gyro_offset(off_ff),
      .gyro_thresh(thr_ff), .gyro_weight(wgt_ff), .gyro_scale(scl_ff),
      .rsp_pos_x(rsp_pos_x), .rsp_pos_y(rsp_pos_y), .rsp_heading(rsp_heading)
   );
endmodule

// ===== rtl/core/gfop_ctrl.sv =====
// Sequencer that walks one beat through the pose datapath.
`timescale 1ns / 1ps
module gfop_ctrl #(
   parameter int ANGLE_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gfop_pkg::cmd_type cmd
);
   import gfop_pkg::*;

   localparam int Iters = (ANGLE_BITS > AtanEntries) ? AtanEntries : ANGLE_BITS;
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRE  = 3'd1;
   localparam logic [2:0] ST_ROT  = 3'd2;
   localparam logic [2:0] ST_FIN  = 3'd3;
   localparam logic [2:0] ST_ACC  = 3'd4;
   localparam int PreSteps = 5;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rv_ff, rv_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rv_in    = rv_ff && rsp_stall;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PRE;
               cnt_in   = '0;
            end
         end
         ST_PRE: begin
            cmd.step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(PreSteps - 1)) begin
               cmd.init = 1'b1;
               cnt_in   = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cmd.rot = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(Iters - 1)) state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // The result register must be free before it is overwritten.
            if (!rv_ff || !rsp_stall) begin
               cmd.acc  = 1'b1;
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rv_ff    <= rv_in;
      end
   end
endmodule

// ===== rtl/core/gfop_dp.sv =====
// Datapath: wheel deltas, heading fusion, iterative CORDIC and pose accumulators.
`timescale 1ns / 1ps
module gfop_dp (
   input  logic              clock,
   input  logic              reset,
   input  gfop_pkg::cmd_type cmd,
   input  logic              req_ticks_valid,
   input  logic [31:0]       req_left_count,
   input  logic [31:0]       req_right_count,
   input  logic [15:0]       req_gyro_rate,
   input  logic [15:0]       dist_per_tick,
   input  logic [15:0]       head_per_mm,
   input  logic [15:0]       gyro_offset,
   input  logic [14:0]       gyro_thresh,
   input  logic [8:0]        gyro_weight,
   input  logic [23:0]       gyro_scale,
   output logic [31:0]       rsp_pos_x,
   output logic [31:0]       rsp_pos_y,
   output logic [15:0]       rsp_heading
);
   import gfop_pkg::*;

   logic [31:0] last_l_ff, last_r_ff, x_ff, y_ff;
   logic [15:0] hd_ff;
   logic [2:0]  ph_ff;
   logic        tv_ff;
   logic signed [31:0] dl_ff, dr_ff;      // count deltas, then unused
   logic signed [15:0] rate_ff;
   logic signed [48:0] pl_ff, pr_ff;      // wheel travel Q40.8
   logic signed [31:0] drob_ff, diff_ff;
   logic signed [16:0] g_ff;
   logic signed [15:0] enc_ff, gyr_ff;
   logic [8:0]         w_ff;
   logic signed [15:0] dth_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [32:0] cz_ff;
   logic [4:0]         it_ff;
   logic               flip_ff;
   logic signed [31:0] xr_ff, yr_ff;
   logic [31:0]        xo_ff, yo_ff;
   logic [15:0]        ho_ff;

   // Combinational pieces of each stage.
   logic signed [49:0] sum_lr, dif_lr;
   logic signed [48:0] encp, gyrp;
   logic signed [32:0] enc_r, gyr_r;
   logic [16:0]        gmag;
   logic signed [26:0] fuse;
   logic [31:0]        mid, ang;
   logic signed [33:0] xs, ys;
   logic signed [32:0] at;
   logic signed [33:0] cxs, cys;
   logic signed [65:0] px, py;
   logic signed [65:0] rx, ry;

   function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
      if (v > 33'sd32767) return 16'sh7FFF;
      if (v < -33'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   always_comb begin
      sum_lr = 50'(pl_ff) + 50'(pr_ff);
      dif_lr = 50'(pr_ff) - 50'(pl_ff);
      encp   = 49'(diff_ff) * $signed({1'b0, head_per_mm});
      enc_r  = 33'((encp + 49'sd32768) >>> 16);
      gyrp   = 49'(g_ff) * $signed({1'b0, gyro_scale});
      gyr_r  = 33'((gyrp + 49'sd8388608) >>> 24);
      gmag   = g_ff[16] ? 17'(-g_ff) : 17'(g_ff);
      fuse   = (27'($signed({1'b0, 9'd256 - w_ff})) * 27'(enc_ff)
               + 27'($signed({1'b0, w_ff})) * 27'(gyr_ff) + 27'sd128) >>> 8;
      mid    = {hd_ff, 16'h0} + {dth_ff[15], dth_ff, 15'h0};
      ang    = (mid[31:30] == 2'b01 || mid[31:30] == 2'b10) ? mid + 32'h80000000 : mid;
      xs     = cx_ff >>> it_ff;
      ys     = cy_ff >>> it_ff;
      at     = $signed({1'b0, atan_lookup(it_ff)});
      // The sign flip of the folded angle goes in before the rounding shift.
      cxs    = flip_ff ? -cx_ff : cx_ff;
      cys    = flip_ff ? -cy_ff : cy_ff;
      px     = 66'(drob_ff) * 66'(cxs);
      py     = 66'(drob_ff) * 66'(cys);
      rx     = (px + 66'sd536870912) >>> 30;
      ry     = (py + 66'sd536870912) >>> 30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_l_ff <= '0;
         last_r_ff <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         hd_ff     <= '0;
         ph_ff     <= '0;
      end else begin
         if (cmd.load) begin
            tv_ff   <= req_ticks_valid;
            rate_ff <= req_gyro_rate;
            dl_ff   <= req_left_count - last_l_ff;
            dr_ff   <= req_right_count - last_r_ff;
            ph_ff   <= '0;
            if (req_ticks_valid) begin
               last_l_ff <= req_left_count;
               last_r_ff <= req_right_count;
            end
         end
         if (cmd.step) begin
            ph_ff <= ph_ff + 3'd1;
            case (ph_ff)
               3'd0: begin
                  pl_ff <= 49'(dl_ff) * $signed({1'b0, dist_per_tick});
                  pr_ff <= 49'(dr_ff) * $signed({1'b0, dist_per_tick});
                  g_ff  <= 17'(rate_ff) - 17'($signed(gyro_offset));
               end
               3'd1: begin
                  if (!tv_ff) drob_ff <= '0;
                  else if ((sum_lr >>> 1) > 50'sd2147483647) drob_ff <= 32'sh7FFFFFFF;
                  else if ((sum_lr >>> 1) < -50'sd2147483648) drob_ff <= 32'sh80000000;
                  else drob_ff <= 32'(sum_lr >>> 1);
                  if (dif_lr > 50'sd2147483647) diff_ff <= 32'sh7FFFFFFF;
                  else if (dif_lr < -50'sd2147483648) diff_ff <= 32'sh80000000;
                  else diff_ff <= dif_lr[31:0];
                  w_ff <= (gyro_weight > 9'd256) ? 9'd256 : gyro_weight;
               end
               3'd2: begin
                  enc_ff <= tv_ff ? sat16(enc_r) : 16'sd0;
                  gyr_ff <= sat16(gyr_r);
                  if (gmag < {2'b0, gyro_thresh}) w_ff <= '0;
               end
               3'd3: dth_ff <= fuse[15:0];
               default: ;
            endcase
         end
         if (cmd.init) begin
            // Seed the rotator from the mid-step angle.
            flip_ff <= (mid[31:30] == 2'b01 || mid[31:30] == 2'b10);
            cz_ff   <= 33'($signed(ang));
            cx_ff   <= CordicGain;
            cy_ff   <= '0;
            it_ff   <= '0;
         end
         if (cmd.rot) begin
            it_ff <= it_ff + 5'd1;
            if (!cz_ff[32]) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - at;
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + at;
            end
         end
         if (cmd.fin) begin
            xr_ff <= rx[31:0];
            yr_ff <= ry[31:0];
         end
         if (cmd.acc) begin
            x_ff  <= x_ff + xr_ff;
            y_ff  <= y_ff + yr_ff;
            hd_ff <= hd_ff + dth_ff;
            xo_ff <= x_ff + xr_ff;
            yo_ff <= y_ff + yr_ff;
            ho_ff <= hd_ff + dth_ff;
         end
      end
   end

   assign rsp_pos_x   = xo_ff;
   assign rsp_pos_y   = yo_ff;
   assign rsp_heading = ho_ff;
endmodule

// ===== tb/tb_gyro_fused_odometry_pose_top.sv =====
// Self-checking testbench for the gyro-fused odometry pose block.
`timescale 1ns / 1ps
module tb_gyro_fused_odometry_pose_top;
   import gfop_pkg::*;

   localparam int Iterations = 16;
   localparam longint GainQ30 = 64'sd652032874;
   localparam int CycleLimit = 3000000;

   typedef struct {
      logic        tv;
      logic [31:0] left;
      logic [31:0] right;
      logic [15:0] gyro;
   } beat_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] h;
   } pose_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_ticks_valid;
   logic [31:0] req_left_count;
   logic [31:0] req_right_count;
   logic [15:0] req_gyro_rate;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_pos_x;
   logic [31:0] rsp_pos_y;
   logic [15:0] rsp_heading;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;

   gyro_fused_odometry_pose_top dut (.*);

   // Mirror of the block's registers and pose state.
   logic [15:0] m_dist, m_hpm, m_offset;
   logic [14:0] m_thresh;
   logic [8:0]  m_weight;
   logic [23:0] m_scale;
   logic [31:0] m_last_l, m_last_r, m_x, m_y;
   logic [15:0] m_head;

   logic [31:0] atan_q32 [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   beat_type  pending_beats [$];
   pose_type  expected_poses [$];
   int     mismatches = 0;
   int     cycles = 0;
   logic   took;
   int     req_gap = 0;
   int     stall_left = 0;
   logic [31:0] gen_l = 0, gen_r = 0;

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Advance the mirrored pose by one beat and return the pose it should show.
   function automatic pose_type advance_pose(beat_type b);
      longint dl, dr, diff, travel, enc, g, w, gyr, dtheta, x, y, z, xs, ys;
      logic [31:0] mid, dt32;
      logic flip;
      pose_type p;
      travel = 0;
      enc = 0;
      if (b.tv) begin
         dl = longint'($signed(b.left - m_last_l)) * longint'(m_dist);
         dr = longint'($signed(b.right - m_last_r)) * longint'(m_dist);
         m_last_l = b.left;
         m_last_r = b.right;
         travel = clamp((dl + dr) >>> 1, -64'sd2147483648, 64'sd2147483647);
         diff = clamp(dr - dl, -64'sd2147483648, 64'sd2147483647);
         enc = clamp(round_shift(diff * longint'(m_hpm), 16), -32768, 32767);
      end
      g = longint'($signed(b.gyro)) - longint'($signed(m_offset));
      w = m_weight > 256 ? 256 : longint'(m_weight);
      if ((g < 0 ? -g : g) < longint'(m_thresh)) w = 0;
      gyr = clamp(round_shift(g * longint'(m_scale), 24), -32768, 32767);
      dtheta = ((256 - w) * enc + w * gyr + 128) >>> 8;
      dt32 = dtheta[31:0];
      mid = {m_head, 16'h0} + (dt32 << 15);
      // Fold the left half-plane onto the right one; undo with a sign flip.
      flip = (mid[31:30] == 2'd1 || mid[31:30] == 2'd2);
      if (flip) mid = mid + 32'h80000000;
      x = GainQ30;
      y = 0;
      z = longint'($signed(mid));
      for (int i = 0; i < Iterations; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(atan_q32[i]);
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(atan_q32[i]);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      m_x = m_x + 32'(round_shift(travel * x, 30));
      m_y = m_y + 32'(round_shift(travel * y, 30));
      m_head = m_head + dtheta[15:0];
      p.x = m_x;
      p.y = m_y;
      p.h = m_head;
      return p;
   endfunction

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("** gyro_fused_odometry_pose_top: FAILED **");
         $finish;
      end
   end

   // Predictor: accepted beats are predicted at the clock edge that takes them.
   always @(posedge clock) begin
      took <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         beat_type b;
         b.tv = req_ticks_valid;
         b.left = req_left_count;
         b.right = req_right_count;
         b.gyro = req_gyro_rate;
         expected_poses.push_back(advance_pose(b));
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_ticks_valid <= 1'b0;
         req_left_count <= '0;
         req_right_count <= '0;
         req_gyro_rate <= '0;
      end else if (req_valid && !took) begin
         // Stalled beat stays put.
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         beat_type b;
         b = pending_beats.pop_front();
         req_ticks_valid <= b.tv;
         req_left_count <= b.left;
         req_right_count <= b.right;
         req_gyro_rate <= b.gyro;
         req_valid <= 1'b1;
         req_gap <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= 1'b0;
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_poses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected pose beat x=%h y=%h h=%h", rsp_pos_x, rsp_pos_y,
                        rsp_heading);
         end else begin
            pose_type e;
            e = expected_poses.pop_front();
            if (e.x !== rsp_pos_x || e.y !== rsp_pos_y || e.h !== rsp_heading) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("pose mismatch: expected x=%h y=%h h=%h, got x=%h y=%h h=%h",
                           e.x, e.y, e.h, rsp_pos_x, rsp_pos_y, rsp_heading);
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_beats.size() > 0 || req_valid || expected_poses.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_DIST_PER_TICK: m_dist = val[15:0];
         CSR_HEAD_PER_MM:   m_hpm = val[15:0];
         CSR_GYRO_OFFSET:   m_offset = val[15:0];
         CSR_GYRO_THRESH:   m_thresh = val[14:0];
         CSR_GYRO_WEIGHT:   m_weight = val[8:0];
         CSR_GYRO_SCALE:    m_scale = val;
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic write_all(logic [23:0] d, logic [23:0] h, logic [23:0] o,
                            logic [23:0] t, logic [23:0] w, logic [23:0] s);
      write_reg(CSR_DIST_PER_TICK, d);
      write_reg(CSR_HEAD_PER_MM, h);
      write_reg(CSR_GYRO_OFFSET, o);
      write_reg(CSR_GYRO_THRESH, t);
      write_reg(CSR_GYRO_WEIGHT, w);
      write_reg(CSR_GYRO_SCALE, s);
   endtask

   task automatic push_beat(logic tv, logic [31:0] l, logic [31:0] r, logic [15:0] g);
      beat_type b;
      b.tv = tv;
      b.left = l;
      b.right = r;
      b.gyro = g;
      pending_beats.push_back(b);
      if (tv) begin
         gen_l = l;
         gen_r = r;
      end
   endtask

   // Mostly plausible wheel motion with a gyro near the threshold band, some noise.
   task automatic push_random_beat();
      int mode;
      logic [31:0] l, r;
      logic [15:0] g;
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
         l = gen_l + $urandom_range(0, 80) - 40;
         r = gen_r + $urandom_range(0, 80) - 40;
      end else if (mode < 85) begin
         l = gen_l + $urandom_range(0, 20000) - 10000;
         r = gen_r + $urandom_range(0, 20000) - 10000;
      end else begin
         l = $urandom;
         r = $urandom;
      end
      if ($urandom_range(0, 4) == 0) g = 16'($urandom);
      else g = 16'($urandom_range(0, 8000) - 4000);
      push_beat($urandom_range(0, 9) != 0, l, r, g);
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_data = '0;
      m_dist = 16'd125;
      m_hpm = 16'd22250;
      m_offset = 16'd0;
      m_thresh = 15'd1280;
      m_weight = 9'd192;
      m_scale = 24'd1192956;
      m_last_l = '0;
      m_last_r = '0;
      m_x = '0;
      m_y = '0;
      m_head = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed beats at the reset register values.
      push_beat(1'b1, 32'd0, 32'd0, 16'd0);
      push_beat(1'b1, 32'd100, 32'd120, 16'd500);
      push_beat(1'b0, 32'd5000, 32'd7000, 16'd3000);
      push_beat(1'b1, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF);
      push_beat(1'b1, 32'h80000000, 32'h7FFFFFFF, 16'h8000);
      push_beat(1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd1279);
      push_beat(1'b1, 32'd0, 32'd0, 16'hFB00);
      push_beat(1'b1, 32'h00001000, 32'h00000F00, 16'd1280);
      wait_idle();

      // Largest settings apart from a zero threshold, weight above one.
      write_all(24'hFFFF, 24'hFFFF, 24'h8000, 24'd0, 24'd511, 24'hFFFFFF);
      push_beat(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF);
      push_beat(1'b1, 32'h80000000, 32'h80000000, 16'h8000);
      push_beat(1'b0, 32'd0, 32'd0, 16'h0000);
      push_beat(1'b1, 32'h00010000, 32'hFFFF0000, 16'h1234);
      push_beat(1'b1, 32'h00010000, 32'h00010000, 16'h8000);
      wait_idle();

      // Smallest settings apart from offset and threshold, which are largest.
      write_all(24'd0, 24'd0, 24'h7FFF, 24'h7FFF, 24'd0, 24'd0);
      push_beat(1'b1, 32'd1000, 32'd3000, 16'h7FFF);
      push_beat(1'b0, 32'd0, 32'd0, 16'h8000);
      push_beat(1'b1, 32'hFFFFFF00, 32'h00000100, 16'h0000);
      wait_idle();

      write_all(24'd256, 24'd22250, 24'd0, 24'd1280, 24'd256, 24'd1192956);
      push_beat(1'b1, 32'd0, 32'd0, 16'h7FFF);
      push_beat(1'b1, 32'd500, 32'd400, 16'd100);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0)
            write_all(24'd125, 24'd22250, 24'd0, 24'd1280, 24'd192, 24'd1192956);
         else
            write_all(24'($urandom_range(0, 1000)), 24'($urandom_range(0, 65535)),
                      24'($urandom_range(0, 400) - 200), 24'($urandom_range(0, 3000)),
                      24'($urandom_range(0, 300)), 24'($urandom_range(0, 16777215)));
         for (int k = 0; k < 210; k++) begin
            push_random_beat();
            // Let the pipe drain completely midway through each phase.
            if (k == 100)
               while (pending_beats.size() > 0 || req_valid || expected_poses.size() > 0)
                  @(posedge clock);
         end
         wait_idle();
      end

      if (mismatches == 0)
         $display("** gyro_fused_odometry_pose_top: PASSED **");
      else
         $display("** gyro_fused_odometry_pose_top: FAILED **");
      $finish;
   end

endmodule
